// File: design/assert_macros.svh
// Assertion helpers for the array list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ALE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ALE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ALE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ALE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/ale_pkg.sv
`timescale 1ns / 1ps
package ale_pkg;
    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [3:0] {
        OP_APPEND = 4'd0, OP_INSERT = 4'd1, OP_DELETE = 4'd2, OP_GET = 4'd3,
        OP_SET = 4'd4, OP_LSEARCH = 4'd5, OP_BSEARCH = 4'd6, OP_SINSERT = 4'd7,
        OP_REVERSE = 4'd8, OP_ROTL = 4'd9, OP_ROTR = 4'd10, OP_QUERY = 4'd11
    } t_op;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] RO_NONE = 2'd0;
    localparam logic [1:0] RO_PREV = 2'd1;
    localparam logic [1:0] RO_FIRST = 2'd2;

    localparam logic CFG_CAP = 1'b0;
    localparam logic CFG_REORDER = 1'b1;

    // per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        CC_HOLD, CC_LOAD_X, CC_SHIFT_UP, CC_SHIFT_DN, CC_SWAP_AB
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_BSRCH, S_REV, S_SUM, S_DONE
    } t_state;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [4:0]  position_in;
        logic signed [31:0] operand_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic signed [31:0] read_value;
        logic [3:0]  found_at;
        logic [4:0]  count;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
        logic signed [35:0] total;
        logic        is_ordered;
    } t_rsp;
endpackage

// File: design/ale_cell.sv
`timescale 1ns / 1ps
// One list slot. Holds a word and moves it to or from its neighbors.
module ale_cell #(
    parameter int WORD_BITS = ale_pkg::WORD_BITS_DEF,
    parameter int IDX_BITS  = 4
) (
    input  logic                  i_clk,
    input  ale_pkg::t_cell_cmd    i_cmd,
    input  logic [IDX_BITS-1:0]   i_self,
    input  logic [IDX_BITS:0]     i_lo,      // first index affected
    input  logic [IDX_BITS:0]     i_hi,      // one past last index in the range
    input  logic [IDX_BITS-1:0]   i_sa,
    input  logic [IDX_BITS-1:0]   i_sb,
    input  logic signed [WORD_BITS-1:0] i_x,
    input  logic signed [WORD_BITS-1:0] i_below, // neighbor at index-1
    input  logic signed [WORD_BITS-1:0] i_above, // neighbor at index+1
    input  logic signed [WORD_BITS-1:0] i_va,
    input  logic signed [WORD_BITS-1:0] i_vb,
    output logic signed [WORD_BITS-1:0] o_word
);
    logic signed [WORD_BITS-1:0] r_word, n_word;
    logic [IDX_BITS:0] w_self;
    logic              w_in;

    assign w_self = {1'b0, i_self};
    assign w_in   = (w_self >= i_lo) && (w_self < i_hi);

    always_comb begin
        n_word = r_word;
        case (i_cmd)
            ale_pkg::CC_LOAD_X:   if (w_self == i_lo) n_word = i_x;
            ale_pkg::CC_SHIFT_UP: if (w_self == i_lo) n_word = i_x;
                                  else if (w_in) n_word = i_below;
            // shift down; the slot just past the range takes i_x (rotate-left tail)
            ale_pkg::CC_SHIFT_DN: if (w_in) n_word = i_above;
                                  else if (w_self == i_hi) n_word = i_x;
            ale_pkg::CC_SWAP_AB: begin
                if (i_self == i_sa) n_word = i_vb;
                else if (i_self == i_sb) n_word = i_va;
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end
    assign o_word = r_word;
endmodule

// File: design/array_list_engine.sv
`timescale 1ns / 1ps
// Channel   Ports                         Handshake
// request   i_start, i_req                accepted when i_start && !o_busy
// result    o_done, o_rsp                 one-cycle strobe, cannot stall
// config    i_cfg_we, i_cfg_idx, i_cfg_data  written when i_cfg_we
// After acceptance, a shift, load or swap lands on the cell row (only when the op
// issues one), then a scan over the filled entries (at least one) computes
// min/max/sum/order, then o_done is raised. Binary search first runs its probes;
// reverse first swaps the pairs in turn, from the ends inward.
// Reset clears fill and state and restores the default config; the cell words are not reset.
// o_busy is high from the cycle after acceptance through the o_done cycle.
`include "assert_macros.svh"
module array_list_engine #(
    parameter int CAPACITY  = ale_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ale_pkg::WORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ale_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output ale_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [4:0]    i_cfg_data
);
    localparam int IB = $clog2(CAPACITY);
    localparam int CB = IB + 1;
    localparam int SB = CB + 1;

    logic signed [WORD_BITS-1:0] w_word [CAPACITY];
    ale_pkg::t_cell_cmd r_cmd;
    logic [CB-1:0] r_lo, r_hi;
    logic [IB-1:0] r_sa, r_sb;
    logic signed [WORD_BITS-1:0] r_x;

    ale_pkg::t_state r_state, n_state;
    logic [CB-1:0] r_fill;
    logic [4:0] r_cap;
    logic [1:0] r_reorder;
    logic [1:0] r_status;
    logic signed [WORD_BITS-1:0] r_rd;
    logic [IB-1:0] r_found;
    logic [CB-1:0] r_i;
    logic signed [SB-1:0] r_bl, r_bh;
    logic signed [WORD_BITS-1:0] r_mn, r_mx;
    logic signed [35:0] r_sum;
    logic r_ord;
    logic [CB-1:0] w_capu;

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ale_cell #(.WORD_BITS(WORD_BITS), .IDX_BITS(IB)) u_cell (
            .i_clk(i_clk), .i_cmd(r_cmd), .i_self(IB'(g)), .i_lo(r_lo), .i_hi(r_hi),
            .i_sa(r_sa), .i_sb(r_sb), .i_x(r_x),
            .i_below(w_word[(g == 0) ? 0 : g - 1]),
            .i_above(w_word[(g == CAPACITY - 1) ? g : g + 1]),
            .i_va(w_word[r_sa]), .i_vb(w_word[r_sb]), .o_word(w_word[g]));
    end

    assign w_capu = (32'(r_cap) > CAPACITY) ? CB'(CAPACITY) : CB'(r_cap);
    assign o_busy = (r_state != ale_pkg::S_IDLE);

    logic signed [WORD_BITS-1:0] w_xi, w_cur, w_nxt;
    logic [CB-1:0] w_pos, w_lhit, w_sidx;
    logic w_hit, w_pos_gt, w_pos_ge, w_rev_more;
    logic signed [SB-1:0] w_mid;
    assign w_xi  = WORD_BITS'(i_req.operand_value);
    assign w_pos = CB'(i_req.position_in);
    assign w_pos_gt = 32'(i_req.position_in) > 32'(r_fill);
    assign w_pos_ge = 32'(i_req.position_in) >= 32'(r_fill);
    assign w_mid = (r_bl + r_bh) >>> 1;
    assign w_cur = w_word[r_i[IB-1:0]];
    assign w_nxt = w_word[(r_i + 1'b1 < r_fill) ? IB'(r_i + 1'b1) : r_i[IB-1:0]];
    // another pair to swap after the one landing this cycle
    assign w_rev_more = (r_cmd == ale_pkg::CC_SWAP_AB) && (CB'(r_sa) + CB'(2) < CB'(r_sb));

    // linear search hit and sorted-insert slot (just above the last entry <= x)
    always_comb begin
        w_hit = 1'b0; w_lhit = '0; w_sidx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (k < r_fill && w_word[k] == w_xi) begin w_hit = 1'b1; w_lhit = CB'(k); end
        end
        for (int k = 0; k < CAPACITY; k++) begin
            if (k < r_fill && w_word[k] <= w_xi) w_sidx = CB'(k + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ale_pkg::S_IDLE; r_fill <= '0; r_cap <= 5'd16;
            r_reorder <= ale_pkg::RO_NONE; r_cmd <= ale_pkg::CC_HOLD;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == ale_pkg::CFG_CAP) r_cap <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == ale_pkg::CFG_REORDER) r_reorder <= i_cfg_data[1:0];
            r_cmd <= ale_pkg::CC_HOLD;
            case (r_state)
                ale_pkg::S_IDLE: if (i_start) begin
                    r_x <= w_xi; r_status <= ale_pkg::ST_OK;
                    r_rd <= '0; r_found <= '0; r_i <= '0;
                    r_hi <= r_fill;
                    case (i_req.opcode)
                        ale_pkg::OP_APPEND, ale_pkg::OP_SINSERT:
                            if (r_fill >= w_capu) r_status <= ale_pkg::ST_FULL;
                            else begin
                                r_cmd <= ale_pkg::CC_SHIFT_UP;
                                r_lo <= (i_req.opcode == ale_pkg::OP_APPEND) ? r_fill : w_sidx;
                                r_hi <= r_fill + 1'b1; r_fill <= r_fill + 1'b1;
                            end
                        ale_pkg::OP_INSERT:
                            if (w_pos_gt) r_status <= ale_pkg::ST_BADIDX;
                            else if (r_fill >= w_capu) r_status <= ale_pkg::ST_FULL;
                            else begin
                                r_cmd <= ale_pkg::CC_SHIFT_UP; r_lo <= w_pos;
                                r_hi <= r_fill + 1'b1; r_fill <= r_fill + 1'b1;
                            end
                        ale_pkg::OP_DELETE, ale_pkg::OP_GET, ale_pkg::OP_SET:
                            if (w_pos_ge) r_status <= ale_pkg::ST_BADIDX;
                            else begin
                                if (i_req.opcode != ale_pkg::OP_SET)
                                    r_rd <= w_word[w_pos[IB-1:0]];
                                if (i_req.opcode == ale_pkg::OP_SET) begin
                                    r_cmd <= ale_pkg::CC_LOAD_X; r_lo <= w_pos;
                                end
                                if (i_req.opcode == ale_pkg::OP_DELETE) begin
                                    r_cmd <= ale_pkg::CC_SHIFT_DN; r_lo <= w_pos;
                                    r_hi <= r_fill - 1'b1; r_fill <= r_fill - 1'b1;
                                end
                            end
                        ale_pkg::OP_LSEARCH:
                            if (!w_hit) r_status <= ale_pkg::ST_NOTFOUND;
                            else begin
                                r_found <= w_lhit[IB-1:0];
                                r_sa <= w_lhit[IB-1:0];
                                if (r_reorder == ale_pkg::RO_PREV && w_lhit != '0) begin
                                    r_cmd <= ale_pkg::CC_SWAP_AB; r_sb <= IB'(w_lhit - 1'b1);
                                end else if (r_reorder == ale_pkg::RO_FIRST) begin
                                    r_cmd <= ale_pkg::CC_SWAP_AB; r_sb <= '0;
                                end
                            end
                        ale_pkg::OP_BSEARCH: begin
                            r_status <= ale_pkg::ST_NOTFOUND;
                            r_bl <= '0; r_bh <= $signed({1'b0, r_fill}) - SB'(1);
                        end
                        ale_pkg::OP_REVERSE: begin
                            r_sa <= '0; r_sb <= IB'(r_fill - 1'b1);
                            if (r_fill > CB'(1)) r_cmd <= ale_pkg::CC_SWAP_AB;
                        end
                        // shift down and drop the old head into the tail slot
                        ale_pkg::OP_ROTL: if (r_fill != '0) begin
                            r_cmd <= ale_pkg::CC_SHIFT_DN; r_lo <= '0; r_hi <= r_fill - 1'b1;
                            r_x <= w_word[0];
                        end
                        ale_pkg::OP_ROTR: if (r_fill != '0) begin
                            r_cmd <= ale_pkg::CC_SHIFT_UP; r_lo <= '0; r_hi <= r_fill;
                            r_x <= w_word[IB'(r_fill - 1'b1)];
                        end
                        default: ;
                    endcase
                end
                ale_pkg::S_BSRCH: if (r_bl <= r_bh) begin
                    if (w_word[w_mid[IB-1:0]] == r_x) begin
                        r_status <= ale_pkg::ST_OK; r_found <= w_mid[IB-1:0];
                        r_bl <= r_bh + SB'(1);
                    end else if (r_x < w_word[w_mid[IB-1:0]]) r_bh <= w_mid - SB'(1);
                    else r_bl <= w_mid + SB'(1);
                end
                // the current pair swaps this cycle; queue the next one
                ale_pkg::S_REV: if (w_rev_more) begin
                    r_cmd <= ale_pkg::CC_SWAP_AB; r_sa <= r_sa + 1'b1; r_sb <= r_sb - 1'b1;
                end
                // scan once the cell command has landed
                ale_pkg::S_SUM: if (r_cmd == ale_pkg::CC_HOLD) begin
                    if (r_i == '0) begin
                        r_mn <= w_cur; r_mx <= w_cur; r_sum <= 36'(w_cur); r_ord <= 1'b1;
                    end else begin
                        if (w_cur < r_mn) r_mn <= w_cur;
                        if (w_cur > r_mx) r_mx <= w_cur;
                        r_sum <= r_sum + 36'(w_cur);
                    end
                    if (r_i + 1'b1 < r_fill && w_cur > w_nxt) r_ord <= 1'b0;
                    r_i <= r_i + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        o_done = 1'b0;
        case (r_state)
            ale_pkg::S_IDLE: if (i_start) begin
                if (i_req.opcode == ale_pkg::OP_BSEARCH) n_state = ale_pkg::S_BSRCH;
                else if (i_req.opcode == ale_pkg::OP_REVERSE) n_state = ale_pkg::S_REV;
                else n_state = ale_pkg::S_SUM;
            end
            ale_pkg::S_BSRCH: if (!(r_bl <= r_bh)) n_state = ale_pkg::S_SUM;
            ale_pkg::S_REV:   if (!w_rev_more) n_state = ale_pkg::S_SUM;
            ale_pkg::S_SUM:   if (r_cmd == ale_pkg::CC_HOLD && r_i + 1'b1 >= r_fill)
                                  n_state = ale_pkg::S_DONE;
            ale_pkg::S_DONE: begin o_done = 1'b1; n_state = ale_pkg::S_IDLE; end
            default: n_state = ale_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.status     = r_status;
        o_rsp.read_value = 32'(r_rd);
        o_rsp.found_at   = 4'(r_found);
        o_rsp.count      = 5'(r_fill);
        o_rsp.smallest   = (r_fill == '0) ? '0 : 32'(r_mn);
        o_rsp.largest    = (r_fill == '0) ? '0 : 32'(r_mx);
        o_rsp.total      = (r_fill == '0) ? '0 : r_sum;
        o_rsp.is_ordered = (r_fill == '0) ? 1'b1 : r_ord;
    end

    `ALE_ASSERT_IMP(a_fill_cap, i_clk, i_rst_n, 1'b1, r_fill <= CB'(CAPACITY), "fill over cap")
    `ALE_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_done, !o_busy, "busy after done")
    `ALE_ASSERT_IMP(a_idle_hold, i_clk, i_rst_n, !o_busy, r_cmd == ale_pkg::CC_HOLD, "idle cmd")
endmodule
